[hw/rtl/sle_pkg.sv]
// Package for the static list engine: request/result structs, codes, sizes.
// Used by sle_store and static_list_engine_core.
`default_nettype none
package sle_pkg;
    localparam int unsigned LIST_CAP_DEF = 128;
    localparam int unsigned VAL_W = 31;

    typedef enum logic [3:0] {
        M_INS_FIRST = 4'd0, M_INS_AT = 4'd1, M_INS_LAST = 4'd2,
        M_DEL_FIRST = 4'd3, M_DEL_AT = 4'd4, M_DEL_LAST = 4'd5,
        M_FIND = 4'd6, M_EXTREMES = 4'd7, M_SORT_ASC = 4'd8,
        M_SORT_DESC = 4'd9, M_CLEAR = 4'd10
    } t_mode;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BADIDX   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [3:0]  mode;
        logic [30:0] value;
        logic [6:0]  position;
    } t_req;

    typedef struct packed {
        logic [30:0] result_value;
        logic [30:0] min_value;
        logic [6:0]  found_position;
        logic [2:0]  status;
        logic [7:0]  length;
    } t_rsp;
endpackage
`default_nettype wire

[hw/rtl/static_list_engine_core.sv]
// Static list engine: left-packed list with a one-port sequencer.
// Rejected, clear, short sort and unused requests go from dispatch straight to done;
// shifts, find and extremes walk one element at a time through read, wait and use;
// sort compares element i with every later element j, then writes i back.
// One request at a time; the result register frees the input once it is taken.
// Reset (synchronous, active low) empties the list; memory contents are kept.
// Depends on sle_pkg and sle_store.
`default_nettype none
module static_list_engine_core #(
    parameter int unsigned LIST_CAPACITY = sle_pkg::LIST_CAP_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire sle_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_stall,
    output sle_pkg::t_rsp      o_rsp
);
    import sle_pkg::*;

    localparam int unsigned AW = $clog2(LIST_CAPACITY);
    localparam int unsigned CW = $clog2(LIST_CAPACITY + 1);
    localparam int unsigned PW = (CW > 7) ? CW + 1 : 8;
    localparam logic [CW-1:0] CAP = CW'(LIST_CAPACITY);

    // one-hot sequencer
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_WAIT  = 10'b0000001000,
        S_USE   = 10'b0000010000,
        S_SRDJ  = 10'b0000100000,
        S_SWAIT = 10'b0001000000,
        S_SCMP  = 10'b0010000000,
        S_SWB   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_end, n_end;
    t_req r_req, n_req;
    t_rsp r_rsp, n_rsp;
    logic r_ovalid, n_ovalid;
    logic [VAL_W-1:0] r_a, n_a;
    logic r_up, n_up;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [VAL_W-1:0] wdata, rdata;
    logic swap;

    sle_store #(.DEPTH(LIST_CAPACITY), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;
    assign swap = r_up ? (r_a > rdata) : (r_a < rdata);

    function automatic logic [PW-1:0] pos_wide_q();
        return PW'(r_req.position);
    endfunction
    function automatic logic [CW-1:0] pos_q();
        return CW'(r_req.position);
    endfunction
    // insert walks read the element left of the write slot
    function automatic logic n_up_ins();
        return !(r_req.mode == M_INS_FIRST || r_req.mode == M_INS_AT
                 || r_req.mode == M_INS_LAST);
    endfunction

    // sequencer
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_i = r_i; n_j = r_j; n_end = r_end;
        n_req = r_req; n_rsp = r_rsp; n_ovalid = r_ovalid; n_a = r_a; n_up = r_up;
        we = 1'b0; waddr = r_i[AW-1:0]; wdata = r_a; raddr = r_i[AW-1:0];
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_req = i_req;
                    n_rsp = '0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                n_up = 1'b1;
                case (r_req.mode)
                    M_INS_FIRST, M_INS_LAST, M_INS_AT: begin
                        if (r_req.mode == M_INS_AT && r_cnt == '0)
                            n_rsp.status = ST_EMPTY;
                        else if (r_cnt >= CAP) n_rsp.status = ST_FULL;
                        else if (r_req.mode == M_INS_AT && pos_wide_q() >= PW'(r_cnt))
                            n_rsp.status = ST_BADIDX;
                        else begin
                            // walk from the tail down to the gap, moving right
                            n_up = 1'b0;
                            n_i = r_cnt;
                            n_a = r_req.value;
                            n_end = (r_req.mode == M_INS_FIRST) ? '0 :
                                    (r_req.mode == M_INS_LAST) ? r_cnt : pos_q();
                            n_cnt = r_cnt + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    M_DEL_FIRST, M_DEL_AT, M_DEL_LAST: begin
                        if (r_cnt == '0) n_rsp.status = ST_EMPTY;
                        else if (r_req.mode == M_DEL_AT && pos_wide_q() >= PW'(r_cnt))
                            n_rsp.status = ST_BADIDX;
                        else begin
                            n_i = (r_req.mode == M_DEL_FIRST) ? '0 :
                                  (r_req.mode == M_DEL_LAST) ? r_cnt - 1'b1 : pos_q();
                            n_end = r_cnt - 1'b1;
                            n_j = '0;
                            n_cnt = r_cnt - 1'b1;
                            n_state = S_RD;
                        end
                    end
                    M_FIND: begin
                        n_rsp.status = ST_NOTFOUND;
                        n_i = '0;
                        if (r_cnt != '0) n_state = S_RD;
                    end
                    M_EXTREMES: begin
                        if (r_cnt == '0) n_rsp.status = ST_EMPTY;
                        else begin
                            n_i = '0;
                            n_state = S_RD;
                        end
                    end
                    M_SORT_ASC, M_SORT_DESC: begin
                        n_up = (r_req.mode == M_SORT_ASC);
                        n_i = '0;
                        if (r_cnt > CW'(1)) n_state = S_RD;
                    end
                    M_CLEAR: n_cnt = '0;
                    default: ;
                endcase
            end
            S_RD: begin
                // read address set up for one element
                if (!n_up_ins()) raddr = r_i[AW-1:0] - 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                // hold the address so the read data stays put
                if (!n_up_ins()) raddr = r_i[AW-1:0] - 1'b1;
                n_state = S_USE;
            end
            S_USE: begin
                n_state = S_DONE;
                case (r_req.mode)
                    M_INS_FIRST, M_INS_AT, M_INS_LAST: begin
                        we = 1'b1;
                        if (r_i == r_end) wdata = r_a;
                        else wdata = rdata;
                        if (r_i != r_end) begin
                            n_i = r_i - 1'b1;
                            n_state = S_RD;
                        end
                    end
                    M_DEL_FIRST, M_DEL_AT, M_DEL_LAST: begin
                        // first read is the removed element; later ones shift left
                        if (r_j == '0) n_rsp.result_value = rdata;
                        else begin
                            we = 1'b1;
                            waddr = r_i[AW-1:0] - 1'b1;
                            wdata = rdata;
                        end
                        n_j = CW'(1);
                        if (r_i + 1'b1 <= r_end) begin
                            n_i = r_i + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    M_FIND: begin
                        if (rdata == r_req.value) begin
                            n_rsp.status = ST_OK;
                            n_rsp.found_position = 7'(r_i);
                        end else if (r_i + 1'b1 < r_cnt) begin
                            n_i = r_i + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    M_EXTREMES: begin
                        if (r_i == '0 || rdata > r_rsp.result_value)
                            n_rsp.result_value = rdata;
                        if (r_i == '0 || rdata < r_rsp.min_value)
                            n_rsp.min_value = rdata;
                        if (r_i + 1'b1 < r_cnt) begin
                            n_i = r_i + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    M_SORT_ASC, M_SORT_DESC: begin
                        // element i held in r_a; sweep j over the tail
                        n_a = rdata;
                        n_j = r_i + 1'b1;
                        n_state = S_SRDJ;
                    end
                    default: ;
                endcase
            end
            S_SRDJ: begin
                raddr = r_j[AW-1:0];
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                raddr = r_j[AW-1:0];
                n_state = S_SCMP;
            end
            S_SCMP: begin
                raddr = r_j[AW-1:0];
                // exchange step: j takes a, i's copy in r_a takes b
                if (swap) begin
                    we = 1'b1;
                    waddr = r_j[AW-1:0];
                    wdata = r_a;
                    n_a = rdata;
                end
                if (r_j + 1'b1 < r_cnt) begin
                    n_j = r_j + 1'b1;
                    n_state = S_SRDJ;
                end else n_state = S_SWB;
            end
            S_SWB: begin
                // write back final element i, move to next i
                we = 1'b1;
                waddr = r_i[AW-1:0];
                wdata = r_a;
                if (r_i + CW'(2) < r_cnt) begin
                    n_i = r_i + 1'b1;
                    n_state = S_RD;
                end else n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid) begin
                    n_rsp.length = 8'(n_cnt);
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_i <= n_i; r_j <= n_j; r_end <= n_end; r_req <= n_req;
        r_rsp <= n_rsp; r_a <= n_a; r_up <= n_up;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP) else $error("count above capacity");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("busy but not stalling");
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_USE || r_state == S_SCMP || r_state == S_SWB))
        else $error("stray write");
`endif
endmodule
`default_nettype wire

[hw/rtl/sle_store.sv]
// Element memory for the static list engine: one write port, one read port,
// registered read data. Depends on sle_pkg.
`default_nettype none
module sle_store #(
    parameter int unsigned DEPTH = sle_pkg::LIST_CAP_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [sle_pkg::VAL_W-1:0] i_wdata,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [sle_pkg::VAL_W-1:0] o_rdata
);
    import sle_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
